[hdl/timed_key_table_top_macros.svh]
// Assertion macros used by the table sequencer.
`ifndef TIMED_KEY_TABLE_TOP_MACROS_SVH
`define TIMED_KEY_TABLE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// A property that holds at every clock edge out of reset.
`define TKT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that implies a consequence in the same cycle.
`define TKT_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// A condition that implies a consequence in the next cycle.
`define TKT_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define TKT_ASSERT(label, clk, rst_n, prop, msg)
`define TKT_ASSERT_IMPL(label, clk, rst_n, a, b, msg)
`define TKT_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

[hdl/tkt_pkg.sv]
package tkt_pkg;

  // Default table depth and the reset value of the keep time register.
  localparam int DEPTH_DEFAULT = 16;
  localparam logic [15:0] KEEP_TIME_RESET = 16'd10;

  // Operation codes.
  localparam logic [2:0] MODE_INSERT       = 3'd0;
  localparam logic [2:0] MODE_LOOKUP_FRESH = 3'd1;
  localparam logic [2:0] MODE_LOOKUP_ANY   = 3'd2;
  localparam logic [2:0] MODE_REMOVE       = 3'd3;
  localparam logic [2:0] MODE_PURGE        = 3'd4;

  // One operation request.
  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] card_number;
    logic [31:0] amount;
    logic [31:0] last_balance;
    logic [31:0] entry_time;
    logic [31:0] now_time;
  } tkt_req_t;

  // One operation result.
  typedef struct packed {
    logic        found;
    logic [31:0] out_amount;
    logic [31:0] out_balance;
    logic [31:0] out_time;
    logic        insert_dropped;
    logic [4:0]  entry_count;
  } tkt_rsp_t;

  // One stored record, as held in the table memory.
  typedef struct packed {
    logic [63:0] card_number;
    logic [31:0] amount;
    logic [31:0] last_balance;
    logic [31:0] entry_time;
  } tkt_rec_t;

  // Sequencer states.
  typedef enum logic {
    TKT_IDLE,
    TKT_SCAN
  } tkt_state_e;

  // An entry is fresh when its time lies in the future or its age is within keep time.
  function automatic logic tkt_fresh(logic [31:0] t, logic [31:0] now, logic [15:0] keep);
    logic [31:0] age;
    age = now - t;
    return (t > now) || (age <= {16'd0, keep});
  endfunction

endpackage

[hdl/tkt_ram.sv]
module tkt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/tkt_seq.sv]
`include "timed_key_table_top_macros.svh"

module tkt_seq #(
  parameter int Depth = tkt_pkg::DEPTH_DEFAULT,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CntW = $clog2(Depth + 1),
  localparam int RecW = $bits(tkt_pkg::tkt_rec_t)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  tkt_pkg::tkt_req_t   req_i,
  input  logic [15:0]         keep_time_i,
  output logic                result_valid_o,
  output tkt_pkg::tkt_rsp_t   rsp_o,
  output logic                mem_we_o,
  output logic [AddrW-1:0]    mem_waddr_o,
  output logic [RecW-1:0]     mem_wdata_o,
  output logic [AddrW-1:0]    mem_raddr_o,
  input  logic [RecW-1:0]     mem_rdata_i
);

  tkt_pkg::tkt_state_e state_q, state_d;
  logic [CntW-1:0]     fill_q, fill_d;
  logic [CntW-1:0]     rd_q, rd_d;
  logic [CntW-1:0]     wr_q, wr_d;
  logic                pend_q, pend_d;
  logic                hit_seen_q, hit_seen_d;
  logic [2:0]          mode_q, mode_d;
  logic [63:0]         key_q, key_d;
  logic [31:0]         now_q, now_d;
  tkt_pkg::tkt_rsp_t   res_q, res_d;
  logic                res_valid_q, res_valid_d;
  tkt_pkg::tkt_rec_t   rec;
  tkt_pkg::tkt_rec_t   ins_rec;
  logic                match;
  logic                fresh;
  logic                is_lookup;
  logic                lookup_hit;
  logic                drop;
  logic                finish;

  assign rec = tkt_pkg::tkt_rec_t'(mem_rdata_i);
  assign ins_rec = '{card_number: req_i.card_number, amount: req_i.amount,
                     last_balance: req_i.last_balance, entry_time: req_i.entry_time};
  assign match = (rec.card_number == key_q);
  assign fresh = tkt_pkg::tkt_fresh(rec.entry_time, now_q, keep_time_i);
  assign is_lookup = (mode_q == tkt_pkg::MODE_LOOKUP_FRESH) ||
                     (mode_q == tkt_pkg::MODE_LOOKUP_ANY);

  // Control and data registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tkt_pkg::TKT_IDLE;
      fill_q      <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      pend_q      <= 1'b0;
      hit_seen_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      pend_q      <= pend_d;
      hit_seen_q  <= hit_seen_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    key_q  <= key_d;
    now_q  <= now_d;
    res_q  <= res_d;
  end

  // Sequencer: inserts write directly; lookup, remove and purge sweep the table with a
  // read pointer, and remove and purge a write pointer that packs survivors toward slot 0.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    pend_d      = 1'b0;
    hit_seen_d  = hit_seen_q;
    mode_d      = mode_q;
    key_d       = key_q;
    now_d       = now_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_q[AddrW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = rd_q[AddrW-1:0];
    lookup_hit  = 1'b0;
    drop        = 1'b0;
    finish      = 1'b0;

    case (state_q)
      tkt_pkg::TKT_IDLE: begin
        if (start_i) begin
          mode_d = req_i.mode;
          key_d  = req_i.card_number;
          now_d  = req_i.now_time;
          res_d  = '0;
          case (req_i.mode)
            tkt_pkg::MODE_INSERT: begin
              if (fill_q == CntW'(Depth)) begin
                res_d.insert_dropped = 1'b1;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = fill_q[AddrW-1:0];
                mem_wdata_o = ins_rec;
                fill_d      = fill_q + 1'b1;
              end
              res_d.entry_count = 5'(fill_d);
              res_valid_d       = 1'b1;
            end
            tkt_pkg::MODE_LOOKUP_FRESH, tkt_pkg::MODE_LOOKUP_ANY,
            tkt_pkg::MODE_REMOVE, tkt_pkg::MODE_PURGE: begin
              state_d    = tkt_pkg::TKT_SCAN;
              rd_d       = '0;
              wr_d       = '0;
              hit_seen_d = 1'b0;
            end
            default: begin
              res_d.entry_count = 5'(fill_q);
              res_valid_d       = 1'b1;
            end
          endcase
        end
      end
      tkt_pkg::TKT_SCAN: begin
        // Judge the entry whose read data has just arrived.
        if (pend_q) begin
          case (mode_q)
            tkt_pkg::MODE_LOOKUP_FRESH: lookup_hit = match && fresh;
            tkt_pkg::MODE_LOOKUP_ANY:   lookup_hit = match;
            tkt_pkg::MODE_REMOVE:       drop = match && !hit_seen_q;
            tkt_pkg::MODE_PURGE:        drop = !fresh;
            default:                    drop = 1'b0;
          endcase
          if (lookup_hit || (drop && (mode_q == tkt_pkg::MODE_REMOVE))) begin
            res_d.found       = 1'b1;
            res_d.out_amount  = rec.amount;
            res_d.out_balance = rec.last_balance;
            res_d.out_time    = rec.entry_time;
            hit_seen_d        = 1'b1;
          end
          if (!is_lookup && !drop) begin
            mem_we_o = 1'b1;
            wr_d     = wr_q + 1'b1;
          end
        end

        // Issue the next read unless a lookup has already hit.
        if ((rd_q != fill_q) && !lookup_hit) begin
          rd_d   = rd_q + 1'b1;
          pend_d = 1'b1;
        end

        finish = lookup_hit || (!pend_q && (rd_q == fill_q));
        if (finish) begin
          if (!is_lookup) begin
            fill_d = wr_q;
          end
          res_d.entry_count = 5'(fill_d);
          res_valid_d       = 1'b1;
          pend_d            = 1'b0;
          state_d           = tkt_pkg::TKT_IDLE;
        end
      end
      default: begin
        state_d = tkt_pkg::TKT_IDLE;
      end
    endcase
  end

  assign busy_o         = (state_q != tkt_pkg::TKT_IDLE);
  assign result_valid_o = res_valid_q;
  assign rsp_o          = res_q;

  `TKT_ASSERT(a_fill_range, clk_i, rst_ni, fill_q <= CntW'(Depth), "fill count above depth")
  `TKT_ASSERT_NEXT(a_insert_grows, clk_i, rst_ni, start_i && !busy_o && (req_i.mode == tkt_pkg::MODE_INSERT) && (fill_q != CntW'(Depth)), fill_q == CntW'($past(fill_q) + 1'b1), "insert did not add an entry")
  `TKT_ASSERT_IMPL(a_write_behind_read, clk_i, rst_ni, (state_q == tkt_pkg::TKT_SCAN) && mem_we_o, wr_q < rd_q, "sweep write overtook the read pointer")
  `TKT_ASSERT_NEXT(a_scan_no_growth, clk_i, rst_ni, state_q == tkt_pkg::TKT_SCAN, fill_q <= $past(fill_q), "table grew during a sweep")
  `TKT_ASSERT_IMPL(a_strobe_idle, clk_i, rst_ni, res_valid_q, state_q == tkt_pkg::TKT_IDLE, "result strobe while sweeping")

endmodule

[hdl/timed_key_table_top.sv]
// Timed key table: an insertion-ordered table of records keyed by card number.
// Operations arrive on the command channel: an operation transfer happens at a
// rising edge with start high and busy low; req_i carries the mode and fields.
// Each operation gives exactly one result on rsp_o, marked by result_valid_o
// for one cycle; the receiver takes it in that cycle and cannot stall it.
// Insert and the unused modes finish without a sweep; busy stays low, so a new
// operation may be taken in the next cycle.
// Lookup, remove and purge sweep the table through the single read port of
// the record memory, one slot a cycle: busy is high until the sweep is done,
// and the result appears in the first cycle with busy low again, when the
// next operation may already be taken. Lookups stop early at the first
// matching entry.
// The keep time register is written through the cfg channel, which is always
// ready; a transfer happens when cfg_valid_i is high. Write it only while idle.
// Reset empties the table and sets keep time to 10 seconds; memory contents
// are left as they are, since the fill count marks which slots hold records.
module timed_key_table_top #(
  parameter int Depth = tkt_pkg::DEPTH_DEFAULT,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int RecW = $bits(tkt_pkg::tkt_rec_t)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tkt_pkg::tkt_req_t req_i,
  output logic              result_valid_o,
  output tkt_pkg::tkt_rsp_t rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i
);

  logic [15:0]      keep_time_q, keep_time_d;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [RecW-1:0]  mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [RecW-1:0]  mem_rdata;

  // Keep time register, loaded on each configuration transfer.
  assign cfg_ready_o = 1'b1;
  assign keep_time_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : keep_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_time_q <= tkt_pkg::KEEP_TIME_RESET;
    end else begin
      keep_time_q <= keep_time_d;
    end
  end

  // Operation sequencer.
  tkt_seq #(
    .Depth(Depth)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .req_i          (req_i),
    .keep_time_i    (keep_time_q),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  // Record memory.
  tkt_ram #(
    .Width(RecW),
    .Depth(Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

[bench/timed_key_table_checker.sv]
module timed_key_table_checker #(
  parameter int Depth = tkt_pkg::DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  tkt_pkg::tkt_req_t req_i,
  input  logic              result_valid_i,
  input  tkt_pkg::tkt_rsp_t rsp_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [15:0]       cfg_data_i,
  output int                mismatches_o,
  output int                awaited_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tkt_pkg::*;

  // Shadow copy of the table, oldest record in slot 0.
  logic [15:0] keep_s;
  tkt_rec_t    slots[Depth];
  int          fill;
  tkt_rsp_t    rsp_due[$];
  tkt_rsp_t    want;
  int          mismatches;

  assign mismatches_o = mismatches;

  // A record is live when its time is ahead of now or its age is within the keep time.
  function automatic logic still_fresh(logic [31:0] stamp, logic [31:0] now);
    logic [31:0] age;
    age = now - stamp;
    return (stamp > now) || (age <= {16'd0, keep_s});
  endfunction

  // Close the gap left by a removed record so insertion order is kept.
  function automatic void remove_at(int idx);
    for (int i = idx; i + 1 < fill; i++) begin
      slots[i] = slots[i + 1];
    end
    fill--;
  endfunction

  // Apply one operation to the shadow table and return the result it should give.
  function automatic tkt_rsp_t table_op(tkt_req_t r);
    tkt_rsp_t o;
    int       i;
    o = '0;
    case (r.mode)
      MODE_INSERT: begin
        if (fill >= Depth) begin
          o.insert_dropped = 1'b1;
        end else begin
          slots[fill].card_number  = r.card_number;
          slots[fill].amount       = r.amount;
          slots[fill].last_balance = r.last_balance;
          slots[fill].entry_time   = r.entry_time;
          fill++;
        end
      end
      MODE_LOOKUP_FRESH, MODE_LOOKUP_ANY, MODE_REMOVE: begin
        for (i = 0; i < fill; i++) begin
          if (slots[i].card_number == r.card_number &&
              (r.mode != MODE_LOOKUP_FRESH || still_fresh(slots[i].entry_time, r.now_time))) begin
            o.found       = 1'b1;
            o.out_amount  = slots[i].amount;
            o.out_balance = slots[i].last_balance;
            o.out_time    = slots[i].entry_time;
            if (r.mode == MODE_REMOVE) begin
              remove_at(i);
            end
            break;
          end
        end
      end
      MODE_PURGE: begin
        i = 0;
        while (i < fill) begin
          if (!still_fresh(slots[i].entry_time, r.now_time)) begin
            remove_at(i);
          end else begin
            i++;
          end
        end
      end
      default: begin
      end
    endcase
    o.entry_count = fill[4:0];
    return o;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  // Predict on every accepted operation and compare every result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_s = KEEP_TIME_RESET;
      fill   = 0;
      rsp_due.delete();
      awaited_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        keep_s = cfg_data_i;
      end
      if (start && !busy) begin
        rsp_due.push_back(table_op(req_i));
      end
      if (result_valid_i) begin
        if (rsp_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with no operation pending, expected no result, actual %0h",
                   $time, rsp_i);
        end else begin
          want = rsp_due.pop_front();
          check_field("found", 64'(want.found), 64'(rsp_i.found));
          check_field("out_amount", 64'(want.out_amount), 64'(rsp_i.out_amount));
          check_field("out_balance", 64'(want.out_balance), 64'(rsp_i.out_balance));
          check_field("out_time", 64'(want.out_time), 64'(rsp_i.out_time));
          check_field("insert_dropped", 64'(want.insert_dropped), 64'(rsp_i.insert_dropped));
          check_field("entry_count", 64'(want.entry_count), 64'(rsp_i.entry_count));
        end
      end
      awaited_o <= rsp_due.size();
    end
  end

endmodule

[bench/timed_key_table_top_tb.sv]
module timed_key_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tkt_pkg::*;

  localparam int          Depth          = DEPTH_DEFAULT;
  localparam logic [63:0] KEY_MAX        = 64'd9999999999999999999;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          SETTLE_CYCLES  = Depth + 6;
  localparam int          PHASES         = 6;
  localparam int          PHASE_OPS      = 200;
  localparam int          BURST_OPS      = 40;

  // Mode codes the block treats as no operation.
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  tkt_req_t    req          = '0;
  logic        result_valid;
  tkt_rsp_t    rsp;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data     = '0;
  int          mismatches;
  int          awaited;
  int          quiet        = 0;

  // Stimulus state.
  int unsigned clock_s;
  logic [15:0] cur_keep;
  int          idle_pct;
  int          insert_wt;
  logic [63:0] keys[4];
  logic [15:0] keep_plan[PHASES];
  int          idle_plan[PHASES] = '{0, 82, 12, 0, 82, 12};
  int          weight_plan[3]    = '{15, 40, 85};
  logic [63:0] key_a;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timed_key_table_top #(.Depth(Depth)) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start         (start),
    .busy          (busy),
    .req_i         (req),
    .result_valid_o(result_valid),
    .rsp_o         (rsp),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  timed_key_table_checker #(.Depth(Depth)) u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start         (start),
    .busy          (busy),
    .req_i         (req),
    .result_valid_i(result_valid),
    .rsp_i         (rsp),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .awaited_o     (awaited)
  );

  // Watchdog: end the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one operation, with a random gap first, and wait for its transfer.
  task automatic send(tkt_req_t r);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  // Stop offering and wait until every pending result has been seen.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  task automatic write_keep(logic [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_keep = value;
  endtask

  function automatic tkt_req_t op(logic [2:0] mode, logic [63:0] key, logic [31:0] amt,
                                  logic [31:0] bal, logic [31:0] stamp, logic [31:0] now);
    tkt_req_t r;
    r.mode         = mode;
    r.card_number  = key;
    r.amount       = amt;
    r.last_balance = bal;
    r.entry_time   = stamp;
    r.now_time     = now;
    return r;
  endfunction

  // A random card number that stays within the legal key range.
  function automatic logic [63:0] rand_key();
    logic [63:0] k;
    k = {$urandom(), $urandom()};
    if (k > KEY_MAX) begin
      k[63] = 1'b0;
    end
    return k;
  endfunction

  // Random operation over a small key pool, with timestamps clustered around the keep window.
  function automatic tkt_req_t rand_op();
    tkt_req_t    r;
    logic [2:0]  mode;
    logic [31:0] now;
    logic [31:0] stamp;
    logic [31:0] keep32;
    keep32 = {16'd0, cur_keep};
    if ($urandom_range(99) < insert_wt) begin
      mode = MODE_INSERT;
    end else begin
      case ($urandom_range(9))
        0, 1, 2: mode = MODE_LOOKUP_FRESH;
        3, 4:    mode = MODE_LOOKUP_ANY;
        5, 6, 7: mode = MODE_REMOVE;
        8:       mode = MODE_PURGE;
        default: mode = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
      endcase
    end
    clock_s += $urandom_range(3);
    now = ($urandom_range(15) == 0) ? $urandom() : clock_s;
    case ($urandom_range(6))
      0:       stamp = now - keep32;
      1:       stamp = now - keep32 - 1;
      2:       stamp = now - $urandom_range(keep32);
      3:       stamp = now + $urandom_range(4, 1);
      4:       stamp = $urandom();
      default: stamp = now - $urandom_range(3 * keep32 + 3);
    endcase
    r = op(mode, ($urandom_range(15) == 0) ? rand_key() : keys[$urandom_range(3)],
           $urandom(), $urandom(), stamp, now);
    return r;
  endfunction

  initial begin
    cur_keep = KEEP_TIME_RESET;
    idle_pct = 0;
    clock_s  = 1000;
    key_a    = 64'h1234_5678_9abc_def0;
    keep_plan = '{16'd0, 16'hffff, 16'd1, 16'($urandom_range(65534, 2)), 16'd300,
                  KEEP_TIME_RESET};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, spare modes, extreme records, duplicates around the age limit.
    send(op(MODE_LOOKUP_FRESH, 64'd0, '0, '0, '0, clock_s));
    send(op(MODE_REMOVE, KEY_MAX, '0, '0, '0, clock_s));
    send(op(MODE_PURGE, 64'd0, '0, '0, '0, '0));
    for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
      send(op(3'(m), KEY_MAX, '1, '1, '1, '1));
    end
    send(op(MODE_INSERT, 64'd0, '0, '0, '0, '0));
    send(op(MODE_INSERT, KEY_MAX, '1, '1, '1, '1));
    send(op(MODE_INSERT, key_a, 32'd1, 32'd11, clock_s - 11, clock_s));
    send(op(MODE_INSERT, key_a, 32'd2, 32'd22, clock_s - 10, clock_s));
    send(op(MODE_INSERT, key_a, 32'd3, 32'd33, clock_s + 5, clock_s));
    send(op(MODE_LOOKUP_FRESH, key_a, '0, '0, '0, clock_s));
    send(op(MODE_LOOKUP_ANY, key_a, '0, '0, '0, clock_s));
    send(op(MODE_LOOKUP_FRESH, KEY_MAX, '0, '0, '0, clock_s));
    send(op(MODE_LOOKUP_FRESH, 64'd0, '0, '0, '0, clock_s));
    send(op(MODE_LOOKUP_ANY, 64'd0, '0, '0, '0, clock_s));
    send(op(MODE_REMOVE, key_a, '0, '0, '0, clock_s));
    send(op(MODE_LOOKUP_ANY, key_a, '0, '0, '0, clock_s));
    send(op(MODE_PURGE, 64'd0, '0, '0, '0, clock_s + 1));
    send(op(MODE_REMOVE, key_a, '0, '0, '0, clock_s));
    send(op(MODE_LOOKUP_ANY, key_a, '0, '0, '0, clock_s));
    send(op(MODE_INSERT, key_a, '1, '0, 32'hffff_fffa, 32'd4));
    send(op(MODE_LOOKUP_FRESH, key_a, '0, '0, '0, 32'd4));

    // Random phases, each with its own keep time and sender pacing.
    for (int p = 0; p < PHASES; p++) begin
      write_keep(keep_plan[p]);
      idle_pct = idle_plan[p];
      for (int n = 0; n < PHASE_OPS; n++) begin
        if (n % BURST_OPS == 0) begin
          keys[0]   = rand_key();
          keys[1]   = rand_key();
          keys[2]   = keys[0] ^ 64'd1;
          keys[3]   = $urandom_range(1) ? 64'd0 : KEY_MAX;
          insert_wt = weight_plan[$urandom_range(2)];
        end
        // Let the block run dry in the middle of every phase.
        if (n == PHASE_OPS / 2) begin
          drain();
        end
        send(rand_op());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
